### hw/rtl/fmit_pkg.sv
// ----------------------------------------------------------------------------
// fmit_pkg
// Shared constants and types of the frog model infection time core.
// ----------------------------------------------------------------------------
package fmit_pkg;

    localparam int MaxFrogsDefault   = 65536;
    localparam int GridWidthDefault  = 2048;
    localparam int GridHeightDefault = 512;

    localparam logic [63:0] MixMult = 64'h2545F4914F6CDD1D;

    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_LIMIT    = 2'd1;
    localparam logic [1:0] OUT_OVERFLOW = 2'd2;

    localparam logic [2:0] CFG_TARGET_X = 3'd0;
    localparam logic [2:0] CFG_WIN_LO   = 3'd1;
    localparam logic [2:0] CFG_WIN_HI   = 3'd2;
    localparam logic [2:0] CFG_Y_HALF   = 3'd3;
    localparam logic [2:0] CFG_BOX_LO   = 3'd4;
    localparam logic [2:0] CFG_BOX_HI   = 3'd5;
    localparam logic [2:0] CFG_LIMIT    = 3'd6;

    typedef struct packed {
        logic [10:0] target_x;
        logic signed [11:0] window_x_low;
        logic [10:0] window_x_high;
        logic [7:0]  y_half_extent;
        logic signed [12:0] box_x_low;
        logic [11:0] box_x_high;
        logic [23:0] step_limit;
    } cfg_t;

    // xorshift64 state update
    function automatic logic [63:0] xs_next(input logic [63:0] s);
        logic [63:0] x;
        x = s ^ (s >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x;
    endfunction

    // reflect once off walls; computed at 15 bits, result wraps to store width
    function automatic logic signed [14:0] reflect(input logic signed [14:0] v,
                                                   input logic signed [14:0] lo,
                                                   input logic signed [14:0] hi);
        logic signed [14:0] r;
        r = v;
        if (v > hi)
            r = (hi <<< 1) - v;
        else if (v < lo)
            r = (lo <<< 1) - v;
        return r;
    endfunction

endpackage

### hw/rtl/fmit_rng.sv
// ----------------------------------------------------------------------------
// fmit_rng
// xorshift64* direction generator: the direction comes combinationally from
// the updated state, which is stored when the generator advances.
// ----------------------------------------------------------------------------
module fmit_rng
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [63:0] seed,
    input  logic        advance,
    output logic [1:0]  dir
);
    import fmit_pkg::*;

    logic [63:0] state_reg;
    logic [63:0] state_next;

    // only the low two product bits matter: they depend on low two bits only
    assign state_next = xs_next(state_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (load)
            state_reg <= seed | 64'd1;
        else if (advance)
            state_reg <= state_next;
    end

    logic [1:0] prod;
    assign prod = 2'(state_next[1:0] * MixMult[1:0]);
    assign dir  = prod;
endmodule

### hw/rtl/fmit_frog_mem.sv
// ----------------------------------------------------------------------------
// fmit_frog_mem
// Frog position store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmit_frog_mem #(
    parameter int Depth = fmit_pkg::MaxFrogsDefault,
    localparam int Aw = $clog2(Depth)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [Aw-1:0] waddr,
    input  logic [21:0]   wdata,
    input  logic [Aw-1:0] raddr,
    output logic [21:0]   rdata
);
    logic [21:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/fmit_visit_mem.sv
// ----------------------------------------------------------------------------
// fmit_visit_mem
// Visited-site bitmap, one row per word, read-modify-write by the sequencer.
// ----------------------------------------------------------------------------
module fmit_visit_mem #(
    parameter int Words = 512,
    parameter int Width = 2048,
    localparam int Aw = (Words > 1) ? $clog2(Words) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [Aw-1:0]    waddr,
    input  logic [Width-1:0] wdata,
    input  logic [Aw-1:0]    raddr,
    output logic [Width-1:0] rdata
);
    logic [Width-1:0] mem [Words];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/frog_model_infection_time_core.sv
// ----------------------------------------------------------------------------
// frog_model_infection_time_core
// One frog-model trial per request: walks all frogs each step, wakes frogs on
// first visits of the window, reports target hit, step limit or overflow.
// ----------------------------------------------------------------------------
//  channel  | signals                          | handshake
//  request  | start, trial_seed                | taken when start && !busy
//  result   | done, outcome, hit_step          | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data      | write on cfg_we
//
//  Each trial first clears the visited bitmap, one row a cycle. Each step then
//  runs a move pass over all frogs, then a wake scan of all frogs with an extra
//  bitmap read-modify-write state for each frog inside the window, and then
//  an append of the woken frogs into the frog store.
//  busy is high from acceptance to the done strobe; reset aborts a trial.
// ----------------------------------------------------------------------------
module frog_model_infection_time_core #(
    parameter int MAX_FROGS   = fmit_pkg::MaxFrogsDefault,
    parameter int GRID_WIDTH  = fmit_pkg::GridWidthDefault,
    parameter int GRID_HEIGHT = fmit_pkg::GridHeightDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] trial_seed,
    output logic        done,
    output logic [1:0]  outcome,
    output logic [23:0] hit_step,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import fmit_pkg::*;

    localparam int Aw  = $clog2(MAX_FROGS);
    localparam int Cw  = Aw + 1;
    localparam int Rw  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int Xw  = $clog2(GRID_WIDTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_MARK0 = 4'd2;
    localparam logic [3:0] S_MRD   = 4'd3;
    localparam logic [3:0] S_MWAIT = 4'd4;
    localparam logic [3:0] S_MWR   = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SWAIT = 4'd7;
    localparam logic [3:0] S_SCHK  = 4'd8;
    localparam logic [3:0] S_SMAP  = 4'd9;
    localparam logic [3:0] S_ARD   = 4'd10;
    localparam logic [3:0] S_AWAIT = 4'd11;
    localparam logic [3:0] S_AWR   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;
    localparam logic [3:0] S_ORIG  = 4'd14;

    // ---------------- configuration ----------------
    cfg_t cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_x      <= 11'd1024;
            cfg_reg.window_x_low  <= -12'sd102;
            cfg_reg.window_x_high <= 11'd1126;
            cfg_reg.y_half_extent <= 8'd181;
            cfg_reg.box_x_low     <= -13'sd204;
            cfg_reg.box_x_high    <= 12'd1228;
            cfg_reg.step_limit    <= 24'd800000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_X: cfg_reg.target_x      <= cfg_data[10:0];
                CFG_WIN_LO:   cfg_reg.window_x_low  <= cfg_data[11:0];
                CFG_WIN_HI:   cfg_reg.window_x_high <= cfg_data[10:0];
                CFG_Y_HALF:   cfg_reg.y_half_extent <= cfg_data[7:0];
                CFG_BOX_LO:   cfg_reg.box_x_low     <= cfg_data[12:0];
                CFG_BOX_HI:   cfg_reg.box_x_high    <= cfg_data[11:0];
                CFG_LIMIT:    cfg_reg.step_limit    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------- control registers ----------------
    logic [3:0]    state_reg, state_next;
    logic [Cw-1:0] total_reg, total_next;
    logic [Cw-1:0] idx_reg, idx_next;     // frog index in pass
    logic [Cw-1:0] pend_reg, pend_next;   // woken this step (pending count)
    logic [Rw-1:0] row_reg, row_next;
    logic [23:0]   step_reg, step_next;
    logic [1:0]    res_out_reg, res_out_next;
    logic [23:0]   res_step_reg, res_step_next;
    logic          done_reg, done_next;
    logic signed [12:0] cx_reg, cx_next;  // current frog x
    logic signed [8:0]  cy_reg, cy_next;
    logic [Xw-1:0] col_reg, col_next;

    // memories
    logic          f_we, p_we, v_we, rng_load, rng_adv;
    logic [Aw-1:0] f_waddr, f_raddr, p_waddr, p_raddr;
    logic [21:0]   f_wdata, f_rdata, p_wdata, p_rdata;
    logic [Rw-1:0] v_waddr, v_raddr;
    logic [GRID_WIDTH-1:0] v_wdata, v_rdata;
    logic [1:0]    dir;

    fmit_frog_mem #(.Depth(MAX_FROGS)) u_frog (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));
    fmit_frog_mem #(.Depth(MAX_FROGS)) u_pend (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));
    fmit_visit_mem #(.Words(GRID_HEIGHT), .Width(GRID_WIDTH)) u_visit (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata));
    fmit_rng u_rng (
        .clk(clk), .rst_n(rst_n), .load(rng_load), .seed(trial_seed),
        .advance(rng_adv), .dir(dir));

    // ---------------- datapath helpers ----------------
    logic signed [14:0] wlo15, whi15, h15, blo15, bhi15, mx, my, rx, ry;
    logic signed [14:0] fx15, fy15, col15, row15;
    logic in_win, map_ok, tgt;
    logic signed [12:0] rdx;
    logic signed [8:0]  rdy;

    always_comb
    begin
        wlo15 = 15'(cfg_reg.window_x_low);
        whi15 = 15'($signed({1'b0, cfg_reg.window_x_high}));
        h15   = 15'($signed({1'b0, cfg_reg.y_half_extent}));
        blo15 = 15'(cfg_reg.box_x_low);
        bhi15 = 15'($signed({1'b0, cfg_reg.box_x_high}));
        rdx   = f_rdata[21:9];
        rdy   = f_rdata[8:0];
        mx    = 15'(rdx);
        my    = 15'(rdy);
        unique case (dir)
            2'd0:    mx = mx + 15'sd1;
            2'd1:    mx = mx - 15'sd1;
            2'd2:    my = my + 15'sd1;
            default: my = my - 15'sd1;
        endcase
        rx = reflect(mx, blo15, bhi15);
        ry = reflect(my, -h15, h15);
        fx15  = 15'(cx_reg);
        fy15  = 15'(cy_reg);
        col15 = fx15 - wlo15;
        row15 = fy15 + h15;
        in_win = !(fx15 < wlo15 || fx15 > whi15 || fy15 < -h15 || fy15 > h15);
        map_ok = col15 >= 0 && row15 >= 0
                 && col15 < 15'(GRID_WIDTH) && row15 < 15'(GRID_HEIGHT);
        tgt = fx15 == 15'($signed({1'b0, cfg_reg.target_x})) && fy15 == 0;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        row_next      = row_reg;
        step_next     = step_reg;
        res_out_next  = res_out_reg;
        res_step_next = res_step_reg;
        done_next     = 1'b0;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        col_next      = col_reg;
        f_we = 1'b0; f_waddr = idx_reg[Aw-1:0]; f_wdata = '0;
        f_raddr = idx_reg[Aw-1:0];
        p_we = 1'b0; p_waddr = pend_reg[Aw-1:0]; p_wdata = {cx_reg, cy_reg};
        p_raddr = idx_reg[Aw-1:0];
        v_we = 1'b0; v_waddr = row_reg; v_wdata = v_rdata; v_raddr = row_reg;
        rng_load = 1'b0; rng_adv = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rng_load   = 1'b1;
                    row_next   = '0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                v_we    = 1'b1;
                v_wdata = '0;
                row_next = row_reg + 1'b1;
                if (row_reg == Rw'(GRID_HEIGHT - 1))
                begin
                    f_we       = 1'b1;
                    f_waddr    = '0;
                    f_wdata    = '0;
                    total_next = Cw'(1);
                    step_next  = '0;
                    cx_next    = '0;
                    cy_next    = '0;
                    state_next = S_ORIG;
                end
            end
            S_ORIG:
            begin
                // target at origin is an immediate hit; else mark origin if inside window, row set up for its read
                row_next = row15[Rw-1:0];
                col_next = col15[Xw-1:0];
                if (cfg_reg.target_x == 11'd0)
                begin
                    res_out_next = OUT_HIT; res_step_next = '0;
                    state_next = S_DONE;
                end
                else if (wlo15 <= 0 && whi15 >= 0 && map_ok)
                    state_next = S_MARK0;
                else
                    state_next = S_MRD;
                idx_next = '0;
            end
            S_MARK0:
            begin
                // read issued this cycle at row_reg; write next via SMAP path
                state_next = S_SMAP;
                pend_next  = '0;
                idx_next   = total_reg; // no scan continues after this mark
            end
            // ---- move pass ----
            S_MRD:
            begin
                if (idx_reg == '0)
                begin
                    if (step_reg == cfg_reg.step_limit)
                    begin
                        res_out_next = OUT_LIMIT; res_step_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        step_next  = step_reg + 24'd1;
                        state_next = S_MWAIT;
                    end
                end
                else
                    state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                state_next = S_MWR;
            end
            S_MWR:
            begin
                rng_adv = 1'b1;
                f_we    = 1'b1;
                f_wdata = {rx[12:0], ry[8:0]};
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == total_reg)
                begin
                    idx_next   = '0;
                    pend_next  = '0;
                    state_next = S_SRD;
                end
                else
                    state_next = S_MRD;
            end
            // ---- wake scan ----
            S_SRD:  state_next = S_SWAIT;
            S_SWAIT:
            begin
                cx_next = rdx; cy_next = rdy;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                row_next = row15[Rw-1:0];
                col_next = col15[Xw-1:0];
                v_raddr  = row15[Rw-1:0];
                if (in_win && map_ok)
                    state_next = S_SMAP;  // bitmap row read in flight
                else if (idx_reg + 1'b1 == total_reg)
                begin
                    idx_next = '0;
                    if (pend_reg == '0)
                        state_next = S_MRD;
                    else if ({1'b0, total_reg} + {1'b0, pend_reg}
                             > (Cw + 1)'(MAX_FROGS))
                    begin
                        res_out_next = OUT_OVERFLOW; res_step_next = '0;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_ARD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_SMAP:
            begin
                // read data of row_reg valid now
                if (!v_rdata[col_reg])
                begin
                    v_we = 1'b1;
                    v_wdata = v_rdata;
                    v_wdata[col_reg] = 1'b1;
                end
                if (idx_reg == total_reg)
                begin
                    // origin mark at trial start
                    idx_next = '0;
                    state_next = S_MRD;
                end
                else
                begin
                    if (!v_rdata[col_reg])
                    begin
                        if (tgt)
                        begin
                            res_out_next = OUT_HIT; res_step_next = step_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            if (pend_reg < Cw'(MAX_FROGS))
                                p_we = 1'b1;
                            pend_next = pend_reg + 1'b1;
                        end
                    end
                    if (!(!v_rdata[col_reg] && tgt))
                    begin
                        if (idx_reg + 1'b1 == total_reg)
                        begin
                            idx_next = '0;
                            if (pend_next == '0)
                                state_next = S_MRD;
                            else if ({1'b0, total_reg} + {1'b0, pend_next}
                                     > (Cw + 1)'(MAX_FROGS))
                            begin
                                res_out_next = OUT_OVERFLOW; res_step_next = '0;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_ARD;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            state_next = S_SRD;
                        end
                    end
                end
            end
            // ---- append pending frogs ----
            S_ARD:  state_next = S_AWAIT;
            S_AWAIT: state_next = S_AWR;
            S_AWR:
            begin
                f_we    = 1'b1;
                f_waddr = Aw'(total_reg + idx_reg);
                f_wdata = p_rdata;
                if (idx_reg + 1'b1 == pend_reg)
                begin
                    total_next = total_reg + pend_reg;
                    idx_next   = '0;
                    state_next = S_MRD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ARD;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= '0;
            row_reg   <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            row_reg   <= row_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_out_reg  <= res_out_next;
        res_step_reg <= res_step_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        col_reg      <= col_next;
    end

    assign busy     = state_reg != S_IDLE;
    assign done     = done_reg;
    assign outcome  = res_out_reg;
    assign hit_step = res_step_reg;

    // ---------------- assertions ----------------
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE)
        else $error("done without finishing state");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= Cw'(MAX_FROGS))
        else $error("frog total above store depth");
    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && outcome != OUT_HIT |-> hit_step == 24'd0)
        else $error("hit_step set without hit");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !$past(busy) |-> $past(start))
        else $error("busy without request");
endmodule
